### rtl/fcr_pkg.sv
// Shared types, constants and codes for the FAT16 cluster chain reader.
`default_nettype none

package fcr_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_CHAIN_DEF     = 64;
    localparam int DIR_SHIFT         = 5;
    localparam int CSIZE_W           = 21;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;

    localparam logic [15:0] CHAIN_END = 16'hfff7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SECTORS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_SECTORS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COPIES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SECTORS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ENTRIES     = 3'd5;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_OK        = 3'd1,
        ST_BAD_START = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_OUT_TABLE = 3'd4,
        ST_TOO_LONG  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        W_IDLE,
        W_LOOK,
        W_CALC
    } walk_state_t;

    typedef struct packed {
        logic        opcode;
        logic [11:0] entry_index;
        logic [15:0] entry_value;
        logic [15:0] start_cluster;
        logic [31:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [31:0] source_offset;
        logic [31:0] copy_length;
        logic [31:0] dest_offset;
        logic        last_command;
        status_t     status;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        base;
        logic [CSIZE_W-1:0] csize;
        logic               settled;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/fcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/fcr_cfg.sv
// Volume geometry registers and the pipelined data base and cluster size.
`default_nettype none

module fcr_cfg
    import fcr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    logic [12:0] sector_reg;
    logic [7:0]  clsect_reg;
    logic [15:0] reserved_reg;
    logic [7:0]  copies_reg;
    logic [15:0] tsect_reg;
    logic [15:0] root_reg;
    logic [1:0]  settle_reg;

    logic [28:0]        res_prod_reg;
    logic [23:0]        tc_prod_reg;
    logic [20:0]        root_bytes_reg;
    logic [CSIZE_W-1:0] csize_reg;
    logic [31:0]        tab_prod_reg;
    logic [31:0]        sum_reg;
    logic [31:0]        base_reg;

    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_reg   <= 13'd512;
            clsect_reg   <= 8'd4;
            reserved_reg <= 16'd1;
            copies_reg   <= 8'd2;
            tsect_reg    <= 16'd32;
            root_reg     <= 16'd512;
            settle_reg   <= 2'd3;
        end else begin
            if (wr) begin
                unique case (cfg_index)
                    CFG_SECTOR_BYTES:     sector_reg   <= cfg_data[12:0];
                    CFG_CLUSTER_SECTORS:  clsect_reg   <= cfg_data[7:0];
                    CFG_RESERVED_SECTORS: reserved_reg <= cfg_data;
                    CFG_TABLE_COPIES:     copies_reg   <= cfg_data[7:0];
                    CFG_TABLE_SECTORS:    tsect_reg    <= cfg_data;
                    CFG_ROOT_ENTRIES:     root_reg     <= cfg_data;
                    default: ;
                endcase
                settle_reg <= 2'd3;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // three register stages for the data base: products and shift, then product and sum, then the final add
    always_ff @(posedge aclk) begin
        res_prod_reg   <= 29'(reserved_reg) * 29'(sector_reg);
        tc_prod_reg    <= 24'(copies_reg) * 24'(tsect_reg);
        root_bytes_reg <= 21'(root_reg) << DIR_SHIFT;
        csize_reg      <= CSIZE_W'(sector_reg) * CSIZE_W'(clsect_reg);
        tab_prod_reg   <= 32'(tc_prod_reg) * 32'(sector_reg);
        sum_reg        <= 32'(res_prod_reg) + 32'(root_bytes_reg);
        base_reg       <= sum_reg + tab_prod_reg;
    end

    assign cfg.base    = base_reg;
    assign cfg.csize   = csize_reg;
    assign cfg.settled = (settle_reg == 2'd0);

endmodule

`default_nettype wire

### rtl/fcr_walker.sv
// Table load and cluster chain walk sequencer around the allocation table RAM.
`default_nettype none

module fcr_walker
    import fcr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_CHAIN     = MAX_CHAIN_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cfg_t      cfg,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int KW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;

    walk_state_t state_reg, state_next;

    logic [15:0]   cur_reg, cur_next;
    logic [31:0]   size_reg, size_next;
    logic [31:0]   placed_reg, placed_next;
    logic [KW-1:0] k_reg, k_next;
    logic [31:0]   prod_reg, prod_next;
    out_item_t     out_reg, out_next;
    logic          m_valid_reg, m_valid_next;

    logic          ram_we, ram_re;
    logic [15:0]   ram_rdata;

    logic          out_free, accept;
    logic          start_bad, start_empty;
    logic          out_of_table;
    logic [31:0]   csize, src, placed_sum;
    logic          chain_end, overshoot, too_long, step_last;

    assign out_free    = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign start_bad   = (s_data.start_cluster < 16'd2);
    assign start_empty = (s_data.byte_count == 32'd0);
    assign out_of_table = (32'(cur_reg) >= 32'(TABLE_ENTRIES));
    assign csize       = 32'(cfg.csize);
    assign src         = cfg.base + prod_reg;
    assign placed_sum  = placed_reg + csize;
    assign chain_end   = (ram_rdata >= CHAIN_END);
    assign overshoot   = (placed_sum >= size_reg);
    assign too_long    = (k_reg == KW'(MAX_CHAIN - 1));
    assign step_last   = chain_end || overshoot || too_long;

    fcr_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(s_data.entry_index)),
        .wr_data (s_data.entry_value),
        .rd_en   (ram_re),
        .rd_addr (AW'(cur_reg)),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            W_IDLE: begin
                if (accept && s_data.opcode == OP_READ && !start_bad && !start_empty) begin
                    state_next = W_LOOK;
                end
            end
            W_LOOK: begin
                if (!out_of_table) begin
                    state_next = W_CALC;
                end else if (out_free) begin
                    state_next = W_IDLE;
                end
            end
            W_CALC: begin
                if (out_free) begin
                    state_next = step_last ? W_IDLE : W_LOOK;
                end
            end
            default: state_next = W_IDLE;
        endcase
    end

    always_comb begin
        cur_next     = cur_reg;
        size_next    = size_reg;
        placed_next  = placed_reg;
        k_next       = k_reg;
        prod_next    = prod_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            W_IDLE: begin
                s_ready = cfg.settled && out_free;
                if (accept) begin
                    if (s_data.opcode == OP_WRITE) begin
                        ram_we = (32'(s_data.entry_index) < 32'(TABLE_ENTRIES));
                    end else begin
                        cur_next    = s_data.start_cluster;
                        size_next   = s_data.byte_count;
                        placed_next = 32'd0;
                        k_next      = '0;
                        if (start_bad || start_empty) begin
                            out_next.source_offset = 32'd0;
                            out_next.copy_length   = 32'd0;
                            out_next.dest_offset   = 32'd0;
                            out_next.last_command  = 1'b1;
                            out_next.status        = start_bad ? ST_BAD_START : ST_OK;
                            m_valid_next           = 1'b1;
                        end
                    end
                end
            end
            W_LOOK: begin
                if (!out_of_table) begin
                    ram_re    = 1'b1;
                    prod_next = (32'(cur_reg) - 32'd2) * csize;
                end else if (out_free) begin
                    out_next.source_offset = 32'd0;
                    out_next.copy_length   = 32'd0;
                    out_next.dest_offset   = placed_reg;
                    out_next.last_command  = 1'b1;
                    out_next.status        = ST_OUT_TABLE;
                    m_valid_next           = 1'b1;
                end
            end
            W_CALC: begin
                if (out_free) begin
                    out_next.source_offset = src;
                    out_next.dest_offset   = placed_reg;
                    out_next.last_command  = step_last;
                    m_valid_next           = 1'b1;
                    if (chain_end) begin
                        out_next.copy_length = size_reg - placed_reg;
                        out_next.status      = ST_OK;
                    end else begin
                        out_next.copy_length = csize;
                        if (overshoot) begin
                            out_next.status = (placed_sum == size_reg) ? ST_OK : ST_MISMATCH;
                        end else if (too_long) begin
                            out_next.status = ST_TOO_LONG;
                        end else begin
                            out_next.status = ST_BUSY;
                        end
                    end
                    placed_next = placed_sum;
                    k_next      = KW'(k_reg + 1'b1);
                    cur_next    = ram_rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= W_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        size_reg   <= size_next;
        placed_reg <= placed_next;
        k_reg      <= k_next;
        prod_reg   <= prod_next;
        out_reg    <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### rtl/fat16_cluster_chain_reader_unit.sv
// Top level of the FAT16 cluster chain reader.
`default_nettype none

// A table-write beat produces nothing. A read request is worked on alone: a
// bad start cluster or a zero byte count answers with a single result in the
// next cycle; otherwise each cluster of the chain is one read of the
// allocation table RAM, then the command, and a stall on the result side
// holds the walk. The table RAM has no reset; entries must be loaded before
// a walk reads them. After reset and after every configuration write the
// derived geometry settles, and no input beat is taken until it has.
module fat16_cluster_chain_reader_unit
    import fcr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_CHAIN     = MAX_CHAIN_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    cfg_t cfg;

    fcr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fcr_walker #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CHAIN     (MAX_CHAIN)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_ready_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input taken while a result beat is blocked");

    a_bad_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.opcode == OP_READ && s_data.start_cluster < 16'd2)
        |=> (m_valid && m_data.last_command && m_data.status == ST_BAD_START))
        else $error("bad start cluster not answered next cycle");

    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_command == (m_data.status != ST_BUSY)))
        else $error("last flag and status disagree");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_fat16_cluster_chain_reader_unit.sv
// Self-checking testbench for the FAT16 cluster chain reader: table loads, chain walks, geometry.
module tb_fat16_cluster_chain_reader_unit;
    import fcr_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    fat16_cluster_chain_reader_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // geometry as last written
    logic [31:0] sector_bytes     = 32'd512;
    logic [31:0] cluster_sectors  = 32'd4;
    logic [31:0] reserved_sectors = 32'd1;
    logic [31:0] table_copies     = 32'd2;
    logic [31:0] table_sectors    = 32'd32;
    logic [31:0] root_entries     = 32'd512;

    // fat_tbl follows accepted beats; plan_tbl follows generated ones
    logic [15:0] fat_tbl      [TABLE_ENTRIES_DEF];
    logic [15:0] plan_tbl     [TABLE_ENTRIES_DEF];
    bit          plan_written [TABLE_ENTRIES_DEF];

    in_item_t  pend_q[$];
    out_item_t copy_cmd_q[$];

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    int  items_made   = 0;
    int  beats_in     = 0;
    int  cmds_checked = 0;
    int  errors       = 0;
    int  geometries   = 1;
    int  st_seen [6];
    bit  s_fire       = 1'b0;
    bit  hold_go      = 1'b0;
    bit  hold_done    = 1'b0;
    int  hold_left    = 0;

    function automatic void add_cmd(input bit planning, input logic [31:0] src,
                                    input logic [31:0] len, input logic [31:0] dst,
                                    input logic last, input status_t st);
        out_item_t c;
        c.source_offset = src;
        c.copy_length   = len;
        c.dest_offset   = dst;
        c.last_command  = last;
        c.status        = st;
        if (!planning)
            copy_cmd_q.push_back(c);
    endfunction

    // Walks a chain. Planning mode returns the first unloaded entry it would read, else -1.
    function automatic int chain_walk(input bit planning, input logic [15:0] first,
                                      input logic [31:0] want);
        logic [31:0] cur, placed, csize, base, src, dst;
        logic [15:0] nxt;
        int          k;
        cur   = {16'd0, first};
        csize = sector_bytes * cluster_sectors;
        base  = reserved_sectors * sector_bytes + table_copies * table_sectors * sector_bytes
              + (root_entries << DIR_SHIFT);
        if (first < 2) begin
            add_cmd(planning, 32'd0, 32'd0, 32'd0, 1'b1, ST_BAD_START);
            return -1;
        end
        if (want == 0) begin
            add_cmd(planning, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK);
            return -1;
        end
        placed = 32'd0;
        for (k = 0; k < MAX_CHAIN_DEF; k++) begin
            if (cur >= TABLE_ENTRIES_DEF) begin
                add_cmd(planning, 32'd0, 32'd0, placed, 1'b1, ST_OUT_TABLE);
                return -1;
            end
            if (planning && !plan_written[cur])
                return int'(cur);
            nxt = planning ? plan_tbl[cur] : fat_tbl[cur];
            src = base + (cur - 32'd2) * csize;
            if (nxt >= CHAIN_END) begin
                add_cmd(planning, src, want - placed, placed, 1'b1, ST_OK);
                return -1;
            end
            dst    = placed;
            placed = placed + csize;
            if (placed >= want) begin
                add_cmd(planning, src, csize, dst, 1'b1,
                        (placed == want) ? ST_OK : ST_MISMATCH);
                return -1;
            end
            if (k == MAX_CHAIN_DEF - 1) begin
                add_cmd(planning, src, csize, dst, 1'b1, ST_TOO_LONG);
                return -1;
            end
            add_cmd(planning, src, csize, dst, 1'b0, ST_BUSY);
            cur = {16'd0, nxt};
        end
        return -1;
    endfunction

    function automatic logic [15:0] rand_link();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 16'($urandom_range(CHAIN_END, 16'hffff));
        if (p < 85) return 16'($urandom_range(2, TABLE_ENTRIES_DEF - 1));
        if (p < 90) return 16'($urandom_range(0, 1));
        return 16'($urandom_range(0, 16'hffff));
    endfunction

    task automatic push_write(input logic [11:0] idx, input logic [15:0] val);
        in_item_t it;
        it.opcode        = OP_WRITE;
        it.entry_index   = idx;
        it.entry_value   = val;
        it.start_cluster = 16'($urandom_range(0, 16'hffff));
        it.byte_count    = $urandom;
        plan_tbl[idx]     = val;
        plan_written[idx] = 1'b1;
        pend_q.push_back(it);
        items_made++;
    endtask

    // loads any entry the walk would read before it was written
    task automatic push_read(input logic [15:0] first, input logic [31:0] count);
        in_item_t it;
        int       gap;
        gap = chain_walk(1'b1, first, count);
        while (gap >= 0) begin
            push_write(gap[11:0], rand_link());
            gap = chain_walk(1'b1, first, count);
        end
        it.opcode        = OP_READ;
        it.entry_index   = 12'($urandom_range(0, TABLE_ENTRIES_DEF - 1));
        it.entry_value   = 16'($urandom_range(0, 16'hffff));
        it.start_cluster = first;
        it.byte_count    = count;
        pend_q.push_back(it);
        items_made++;
    endtask

    task automatic push_chain();
        logic [15:0] hop [MAX_CHAIN_DEF];
        logic [15:0] tail;
        logic [31:0] csz, span, count;
        int          len, i, mode;
        len = ($urandom_range(99) < 6) ? $urandom_range(20, MAX_CHAIN_DEF) : $urandom_range(1, 6);
        for (i = 0; i < len; i++)
            hop[i] = 16'($urandom_range(2, TABLE_ENTRIES_DEF - 1));
        mode = $urandom_range(9);
        if (mode < 8)
            tail = 16'($urandom_range(CHAIN_END, 16'hffff));
        else if (mode == 8)
            tail = 16'($urandom_range(TABLE_ENTRIES_DEF, CHAIN_END - 1));
        else
            tail = 16'($urandom_range(0, 1));
        for (i = 0; i < len; i++) begin
            if (i == len - 1)
                push_write(hop[i][11:0], tail);
            else
                push_write(hop[i][11:0], hop[i + 1]);
        end
        csz  = sector_bytes * cluster_sectors;
        span = len * csz;
        if (csz == 0) begin
            count = $urandom;
        end else begin
            case ($urandom_range(4))
                0: count = span;
                1: count = span - ((csz > 1) ? $urandom_range(0, csz - 1) : 0);
                2: count = $urandom_range(1, span);
                3: count = span + $urandom_range(1, 4095);
                default: count = $urandom;
            endcase
        end
        push_read(hop[0], count);
    endtask

    task automatic random_items(input int n);
        int goal;
        int pick;
        goal = items_made + n;
        while (items_made < goal) begin
            pick = $urandom_range(99);
            if (pick < 70)
                push_chain();
            else if (pick < 85)
                push_read(($urandom_range(1)) ? 16'($urandom_range(0, 16'hffff))
                                              : 16'($urandom_range(0, TABLE_ENTRIES_DEF - 1)),
                          ($urandom_range(1)) ? $urandom : $urandom_range(0, 20000));
            else
                push_write(12'($urandom_range(0, TABLE_ENTRIES_DEF - 1)), rand_link());
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_SECTOR_BYTES:     sector_bytes     = {19'd0, val[12:0]};
            CFG_CLUSTER_SECTORS:  cluster_sectors  = {24'd0, val[7:0]};
            CFG_RESERVED_SECTORS: reserved_sectors = {16'd0, val};
            CFG_TABLE_COPIES:     table_copies     = {24'd0, val[7:0]};
            CFG_TABLE_SECTORS:    table_sectors    = {16'd0, val};
            CFG_ROOT_ENTRIES:     root_entries     = {16'd0, val};
            default: ;
        endcase
    endtask

    task automatic apply_geometry(input int sb, input int cs, input int rs,
                                  input int tc, input int ts, input int re);
        cfg_write(CFG_SECTOR_BYTES,     16'(sb));
        cfg_write(CFG_CLUSTER_SECTORS,  16'(cs));
        cfg_write(CFG_RESERVED_SECTORS, 16'(rs));
        cfg_write(CFG_TABLE_COPIES,     16'(tc));
        cfg_write(CFG_TABLE_SECTORS,    16'(ts));
        cfg_write(CFG_ROOT_ENTRIES,     16'(re));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        geometries++;
    endtask

    task automatic random_geometry();
        apply_geometry($urandom_range(1, 4096), $urandom_range(1, 128),
                       $urandom_range(0, 16'hffff), $urandom_range(1, 255),
                       $urandom_range(0, 16'hffff), $urandom_range(0, 16'hffff));
    endtask

    // wait until every beat is sent and every predicted command is seen, then allow a short tail
    task automatic drain();
        @(posedge aclk);
        while (pend_q.size() != 0 || s_valid || copy_cmd_q.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic directed_items();
        push_write(12'd2, 16'd3);
        push_write(12'd3, 16'hffff);
        push_read(16'd2, 32'd3000);              // full cluster then remainder
        push_read(16'd2, 32'd2048);              // exact fit on a full copy
        push_read(16'd2, 32'd1000);              // overshoot, size mismatch
        push_read(16'd2, 32'd0);                 // zero byte count
        push_read(16'd0, 32'd5);                 // bad start
        push_read(16'd1, 32'd5);
        push_read(16'hffff, 32'hffffffff);       // start outside the table
        push_read(16'd3, 32'hffffffff);          // chain end, huge remainder
        push_write(12'd4, 16'(TABLE_ENTRIES_DEF));
        push_read(16'd4, 32'hffffffff);          // runs off the table mid-chain
        push_write(12'd5, 16'd5);
        push_read(16'd5, 32'hffffffff);          // self loop, chain too long
        push_write(12'd6, 16'd0);
        push_write(12'd0, 16'd1);
        push_write(12'd1, CHAIN_END);
        push_read(16'd6, 32'hffffffff);          // low clusters, offsets wrap
        push_write(12'd4095, 16'hfffe);
        push_read(16'd4095, 32'd1);
        push_write(12'd7, CHAIN_END - 16'd1);
        push_read(16'd7, 32'd100);
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_data  <= pend_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long result-side hold-off
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end

    // predictor and checker
    always @(posedge aclk) begin
        out_item_t want;
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            beats_in++;
            if (s_data.opcode == OP_WRITE)
                fat_tbl[s_data.entry_index] = s_data.entry_value;
            else
                void'(chain_walk(1'b0, s_data.start_cluster, s_data.byte_count));
        end
        if (aresetn && m_valid && m_ready) begin
            cmds_checked++;
            if (m_data.status <= ST_TOO_LONG)
                st_seen[m_data.status]++;
            if (copy_cmd_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected command beat: src %h len %h dst %h last %b st %0d",
                             m_data.source_offset, m_data.copy_length, m_data.dest_offset,
                             m_data.last_command, m_data.status);
            end else begin
                want = copy_cmd_q.pop_front();
                if (m_data !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: want src %h len %h dst %h last %b st %0d; got src %h len %h dst %h last %b st %0d",
                                 want.source_offset, want.copy_length, want.dest_offset,
                                 want.last_command, want.status,
                                 m_data.source_offset, m_data.copy_length, m_data.dest_offset,
                                 m_data.last_command, m_data.status);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_fat16_cluster_chain_reader_unit failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 27;
        snk_idle_pct = 64;
        directed_items();
        random_items(35);
        drain();
        apply_geometry(4096, 128, 65535, 255, 65535, 65535);
        random_items(35);
        drain();

        src_idle_pct = 64;
        snk_idle_pct = 27;
        apply_geometry(1, 1, 0, 1, 0, 0);
        random_items(35);
        drain();
        random_geometry();
        random_items(35);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        apply_geometry(512, 0, 1, 2, 32, 512);   // zero cluster size
        random_items(15);
        drain();
        random_geometry();
        hold_go = 1'b1;
        random_items(50);
        drain();
        repeat (20) @(posedge aclk);

        $display("covered %0d input beats and %0d copy commands over %0d geometry settings",
                 beats_in, cmds_checked, geometries);
        $display("statuses: busy %0d ok %0d bad-start %0d mismatch %0d off-table %0d too-long %0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4], st_seen[5]);
        if (errors == 0 && copy_cmd_q.size() == 0) begin
            $display("tb_fat16_cluster_chain_reader_unit passed");
        end else begin
            $display("tb_fat16_cluster_chain_reader_unit failed");
        end
        $finish;
    end

endmodule
